>>> rtl/lfr_pkg.sv
// Shared types, codes and constants of the link frame receiver.
// Used by every module of the block; depends on nothing.
package lfr_pkg;

  // Largest payload length, data check byte included.
  localparam int unsigned MaxPayload = 2048;
  localparam int unsigned CountW = 12;

  // Framing bytes.
  localparam logic [7:0] FlagByte   = 8'h7E;
  localparam logic [7:0] EscByte    = 8'h7D;
  localparam logic [7:0] EscForEsc  = 8'h5D;
  localparam logic [7:0] EscForFlag = 8'h5E;
  localparam logic [7:0] InfoCtrlA  = 8'h00;
  localparam logic [7:0] InfoCtrlB  = 8'h40;

  // Register reset values.
  localparam logic [7:0] AddrCommandRst  = 8'd3;
  localparam logic [7:0] AddrResponseRst = 8'd1;
  localparam logic [7:0] CtrlSetRst      = 8'd3;
  localparam logic [7:0] CtrlDiscRst     = 8'd11;
  localparam logic [7:0] CtrlUaRst       = 8'd7;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAddrCommand  = 3'd0,
    CfgAddrResponse = 3'd1,
    CfgCtrlSet      = 3'd2,
    CfgCtrlDisc     = 3'd3,
    CfgCtrlUa       = 3'd4
  } lfr_cfg_idx_e;

  typedef enum logic {
    OpByte   = 1'b0,
    OpResync = 1'b1
  } lfr_op_e;

  typedef enum logic [3:0] {
    StStart   = 4'd0,
    StFlag    = 4'd1,
    StAddr    = 4'd2,
    StSuCtrl  = 4'd3,
    StSuCheck = 4'd4,
    StICtrl   = 4'd5,
    StData    = 4'd6,
    StEsc     = 4'd7,
    StSuStop  = 4'd8,
    StIStop   = 4'd9
  } lfr_state_e;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindSuEnd = 2'd1,
    KindIEnd  = 2'd2,
    KindAbort = 2'd3
  } lfr_kind_e;

  typedef struct packed {
    logic [7:0] addr_command;
    logic [7:0] addr_response;
    logic [7:0] ctrl_set;
    logic [7:0] ctrl_disc;
    logic [7:0] ctrl_ua;
  } lfr_cfg_t;

  typedef struct packed {
    lfr_kind_e         kind;
    logic [7:0]        byte_value;
    logic [7:0]        frame_address;
    logic [7:0]        frame_control;
    logic [CountW-1:0] payload_count;
  } lfr_result_t;

endpackage

>>> rtl/lfr_cfg_regs.sv
// Configuration register file of the link frame receiver.
// Depends on lfr_pkg for the register indexes, reset values and the struct.
module lfr_cfg_regs import lfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] index_i,
  input  logic [7:0]         data_i,
  output lfr_cfg_t           cfg_o
);

  lfr_cfg_t cfg_q, cfg_d;

  // Decode the register index; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (lfr_cfg_idx_e'(index_i))
        CfgAddrCommand:  cfg_d.addr_command  = data_i;
        CfgAddrResponse: cfg_d.addr_response = data_i;
        CfgCtrlSet:      cfg_d.ctrl_set      = data_i;
        CfgCtrlDisc:     cfg_d.ctrl_disc     = data_i;
        CfgCtrlUa:       cfg_d.ctrl_ua       = data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.addr_command  <= AddrCommandRst;
      cfg_q.addr_response <= AddrResponseRst;
      cfg_q.ctrl_set      <= CtrlSetRst;
      cfg_q.ctrl_disc     <= CtrlDiscRst;
      cfg_q.ctrl_ua       <= CtrlUaRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/lfr_rx_core.sv
// Receive state machine: header checks, destuffing, length count and link flag.
// Depends on lfr_pkg; produces at most one result per accepted item.
module lfr_rx_core import lfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        op_i,
  input  logic [7:0]  byte_i,
  input  lfr_cfg_t    cfg_i,
  output logic        res_valid_o,
  output lfr_result_t res_o
);

  lfr_state_e        state_q, state_d;
  logic              link_up_q, link_up_d;
  logic [7:0]        hdr_address_q, hdr_address_d;
  logic [7:0]        hdr_control_q, hdr_control_d;
  logic [CountW-1:0] len_q, len_d;

  logic [7:0]        check;
  logic              take;
  logic [7:0]        take_value;
  logic              is_addr;
  logic              is_su_ctrl;
  logic              is_i_ctrl;

  assign check      = hdr_address_q ^ hdr_control_q;
  assign is_addr    = (byte_i == cfg_i.addr_command) || (byte_i == cfg_i.addr_response);
  assign is_su_ctrl = (byte_i == cfg_i.ctrl_set) || (byte_i == cfg_i.ctrl_disc) ||
                      (byte_i == cfg_i.ctrl_ua);
  assign is_i_ctrl  = (byte_i == InfoCtrlA) || (byte_i == InfoCtrlB);

  // Next state for one accepted item: a received byte or a resynchronize.
  always_comb begin
    state_d       = state_q;
    link_up_d     = link_up_q;
    hdr_address_d = hdr_address_q;
    hdr_control_d = hdr_control_q;
    len_d         = len_q;
    take          = 1'b0;
    take_value    = byte_i;
    if (fire_i) begin
      if (lfr_op_e'(op_i) == OpResync) begin
        state_d = StStart;
        len_d   = '0;
      end else begin
        unique case (state_q)
          StFlag: begin
            if (is_addr) begin
              hdr_address_d = byte_i;
              state_d       = StAddr;
            end else if (byte_i != FlagByte) begin
              state_d = StStart;
            end
          end
          StAddr: begin
            if (is_su_ctrl) begin
              hdr_control_d = byte_i;
              link_up_d     = 1'b0;
              state_d       = StSuCtrl;
            end else if (byte_i == FlagByte) begin
              state_d = StFlag;
            end else if (is_i_ctrl && link_up_q) begin
              hdr_control_d = byte_i;
              state_d       = StICtrl;
            end else begin
              state_d = StStart;
            end
          end
          StSuCtrl: begin
            if (byte_i == check) state_d = StSuCheck;
            else if (byte_i == FlagByte) state_d = StFlag;
            else state_d = StStart;
          end
          StSuCheck: begin
            if (byte_i == FlagByte) begin
              state_d   = StSuStop;
              link_up_d = 1'b1;
            end else begin
              state_d = StStart;
            end
          end
          StICtrl: begin
            if (byte_i == check) begin
              state_d = StData;
              len_d   = '0;
            end else if (byte_i == FlagByte) begin
              state_d = StFlag;
            end else begin
              state_d = StStart;
            end
          end
          StData: begin
            if (byte_i == EscByte) begin
              state_d = StEsc;
            end else if (byte_i == FlagByte) begin
              state_d = (len_q < CountW'(2)) ? StStart : StIStop;
            end else begin
              take = 1'b1;
            end
          end
          StEsc: begin
            if (byte_i == EscForEsc) begin
              take       = 1'b1;
              take_value = EscByte;
            end else if (byte_i == EscForFlag) begin
              take       = 1'b1;
              take_value = FlagByte;
            end else begin
              state_d = StStart;
            end
          end
          default: begin
            // Start, both stop states and unused codes.
            state_d = (byte_i == FlagByte) ? StFlag : StStart;
          end
        endcase

        // Payload byte: count it, or abort when the frame is already full.
        if (take) begin
          if (len_q >= CountW'(MaxPayload)) begin
            state_d = StStart;
            len_d   = '0;
          end else begin
            state_d = StData;
            len_d   = len_q + CountW'(1);
          end
        end
      end
    end
  end

  // Result for the same byte; the header fields are unchanged whenever one is made.
  always_comb begin
    res_valid_o         = 1'b0;
    res_o.kind          = KindByte;
    res_o.byte_value    = '0;
    res_o.frame_address = hdr_address_q;
    res_o.frame_control = hdr_control_q;
    res_o.payload_count = '0;
    if (fire_i && (lfr_op_e'(op_i) == OpByte)) begin
      if (take) begin
        res_valid_o = 1'b1;
        if (len_q >= CountW'(MaxPayload)) begin
          res_o.kind          = KindAbort;
          res_o.payload_count = len_q;
        end else begin
          res_o.kind          = KindByte;
          res_o.byte_value    = take_value;
          res_o.payload_count = len_d;
        end
      end else if ((state_q == StSuCheck) && (byte_i == FlagByte)) begin
        res_valid_o = 1'b1;
        res_o.kind  = KindSuEnd;
      end else if ((state_q == StData) && (byte_i == FlagByte) &&
                   (len_q >= CountW'(2))) begin
        res_valid_o         = 1'b1;
        res_o.kind          = KindIEnd;
        res_o.payload_count = len_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StStart;
      link_up_q     <= 1'b0;
      hdr_address_q <= '0;
      hdr_control_q <= '0;
      len_q         <= '0;
    end else begin
      state_q       <= state_d;
      link_up_q     <= link_up_d;
      hdr_address_q <= hdr_address_d;
      hdr_control_q <= hdr_control_d;
      len_q         <= len_d;
    end
  end

`ifndef SYNTH
  // The length counter never passes the frame limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CountW'(MaxPayload))
    else $error("payload length beyond limit");

  // A completed supervisory frame brings the link up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KindSuEnd)) |=> link_up_q)
    else $error("link not up after supervisory frame");

  // An overflow abort resynchronizes with a cleared length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KindAbort)) |=> ((state_q == StStart) && (len_q == '0)))
    else $error("abort did not resynchronize");

  // A resynchronize item keeps the link flag and returns to start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (op_i == OpResync)) |=>
      ((state_q == StStart) && (link_up_q == $past(link_up_q))))
    else $error("resynchronize misbehaved");
`endif

endmodule

>>> rtl/lfr_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on lfr_pkg for the result struct.
module lfr_out_buf import lfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lfr_result_t data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        stall_i,
  output lfr_result_t data_o
);

  logic        head_v_q, head_v_d;
  logic        skid_v_q, skid_v_d;
  lfr_result_t head_q, head_d;
  lfr_result_t skid_q, skid_d;
  logic        pop;

  assign pop = head_v_q && !stall_i;

  // Refill the head from the skid entry first, then from a new push.
  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        head_d   = data_i;
        head_v_d = push_i;
      end
    end else if (push_i) begin
      if (!head_v_q) begin
        head_d   = data_i;
        head_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

endmodule

>>> rtl/link_frame_receiver_top.sv
// Link frame receiver: one line byte per item, with a small result buffer.
// Depends on lfr_pkg, lfr_cfg_regs, lfr_rx_core and lfr_out_buf.
//
// The receiver takes one item every clock cycle while in_stall_o is low. Each
// received byte updates the frame state in the same cycle it is accepted, and
// any result it causes reaches the output through a buffer register. Results
// sit in a two-entry buffer (output register plus skid register), so input
// stall rises only when both entries hold results that the downstream side has
// not taken. Configuration registers are written through their own port, which
// is always ready, and should be written only while the receiver is idle.
module link_frame_receiver_top import lfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // Input items.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [7:0]         byte_in_i,
  // Result items.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         byte_value_o,
  output logic [7:0]         frame_address_o,
  output logic [7:0]         frame_control_o,
  output logic [CountW-1:0]  payload_count_o
);

  lfr_cfg_t    cfg;
  lfr_result_t res;
  lfr_result_t out_res;
  logic        res_valid;
  logic        buf_full;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_fire     = in_valid_i && !buf_full;

  lfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  lfr_rx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .op_i        (op_i),
    .byte_i      (byte_in_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lfr_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign kind_o          = out_res.kind;
  assign byte_value_o    = out_res.byte_value;
  assign frame_address_o = out_res.frame_address;
  assign frame_control_o = out_res.frame_control;
  assign payload_count_o = out_res.payload_count;

endmodule
